[src/trpf_pkg.sv]
package trpf_pkg;

  localparam int unsigned PktLen    = 13;
  localparam int unsigned StepW     = $clog2(PktLen);
  localparam int unsigned NumCfg    = 4;
  localparam int unsigned CfgIdxW   = $clog2(NumCfg);

  localparam logic [7:0] PAYLOAD_LEN = 8'd9;
  localparam logic [3:0] EV_MAX_PASS = 4'd8;
  localparam logic [3:0] EV_DOWN_UP  = 4'd9;
  localparam logic [7:0] EV_DOWN     = 8'd4;
  localparam logic [7:0] EV_UP       = 8'd5;

  localparam logic [7:0] SYNC_RST    = 8'd121;
  localparam logic [7:0] ADDR_RST    = 8'd106;
  localparam logic [7:0] MSGID_RST   = 8'd2;
  localparam logic [7:0] END_RST     = 8'd106;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_SYNC  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ADDR  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MSGID = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_END   = 2'd3;

  // Byte source selects of the control word.
  localparam logic [3:0] SRC_SYNC  = 4'd0;
  localparam logic [3:0] SRC_ADDR  = 4'd1;
  localparam logic [3:0] SRC_MSGID = 4'd2;
  localparam logic [3:0] SRC_LEN   = 4'd3;
  localparam logic [3:0] SRC_RID   = 4'd4;
  localparam logic [3:0] SRC_TYPE  = 4'd5;
  localparam logic [3:0] SRC_EVENT = 4'd6;
  localparam logic [3:0] SRC_XL    = 4'd7;
  localparam logic [3:0] SRC_XH    = 4'd8;
  localparam logic [3:0] SRC_YL    = 4'd9;
  localparam logic [3:0] SRC_YH    = 4'd10;
  localparam logic [3:0] SRC_END   = 4'd11;

  typedef struct packed {
    logic [3:0] src;  // byte source
    logic       eop;  // closing byte of a packet
    logic       fin;  // last step: jump back for a second packet or stop
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
    ucode_t w;
    w = '{src: SRC_END, eop: 1'b1, fin: 1'b1};
    case (step)
      4'd0:    w = '{src: SRC_SYNC,  eop: 1'b0, fin: 1'b0};
      4'd1:    w = '{src: SRC_ADDR,  eop: 1'b0, fin: 1'b0};
      4'd2:    w = '{src: SRC_MSGID, eop: 1'b0, fin: 1'b0};
      4'd3:    w = '{src: SRC_LEN,   eop: 1'b0, fin: 1'b0};
      4'd4:    w = '{src: SRC_RID,   eop: 1'b0, fin: 1'b0};
      4'd5:    w = '{src: SRC_TYPE,  eop: 1'b0, fin: 1'b0};
      4'd6:    w = '{src: SRC_EVENT, eop: 1'b0, fin: 1'b0};
      4'd7:    w = '{src: SRC_XL,    eop: 1'b0, fin: 1'b0};
      4'd8:    w = '{src: SRC_XH,    eop: 1'b0, fin: 1'b0};
      4'd9:    w = '{src: SRC_YL,    eop: 1'b0, fin: 1'b0};
      4'd10:   w = '{src: SRC_YH,    eop: 1'b0, fin: 1'b0};
      4'd11:   w = '{src: SRC_END,   eop: 1'b0, fin: 1'b0};
      4'd12:   w = '{src: SRC_END,   eop: 1'b1, fin: 1'b1};
      default: w = '{src: SRC_END,   eop: 1'b1, fin: 1'b1};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] map_type(input logic [2:0] t);
    logic [7:0] r;
    case (t)
      3'd1, 3'd2, 3'd4, 3'd5, 3'd6: r = {5'd0, t};
      default:                      r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

[src/touch_report_packet_framer.sv]
// Touch report packet framer: each record accepted on the in_ stream becomes a 13-byte packet
// (sync, address, message id, length 9, report id, type, event, x low/high, y low/high, two end
// markers) sent one byte per transaction on the out_ stream; an event code of 9 sends two packets,
// event 4 then event 5. A small control-word table stepped by a counter picks each byte, one byte
// per cycle when the output is not stalled, into a single byte-wide output register. The framer
// takes no new record until the last byte of the current one has been loaded, and the next record
// can be accepted at the edge after the final byte has been loaded into the output register.
// out_tuser marks the 13th byte of each packet and out_tlast the final byte of a record.
module touch_report_packet_framer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [7:0] report_id, [15:8] status_byte, [23:16] y_low, [31:24] y_high,
  // [39:32] x_low, [47:40] x_high
  input  logic [47:0]                  in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [7:0] packet_byte
  output logic [7:0]                   out_tdata,
  // [0] end_of_packet
  output logic                         out_tuser,
  output logic                         out_tlast,
  input  logic                         cfg_wr_en,
  input  logic [trpf_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [7:0]                   cfg_wdata
);
  import trpf_pkg::*;

  logic [7:0]       sync_r, addr_r, msgid_r, end_r;
  logic [47:0]      rec_r;
  logic             busy_r, busy_nxt;
  logic             second_r, second_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [7:0]       obyte_r, obyte_nxt;
  logic             oeop_r, oeop_nxt;
  logic             olast_r, olast_nxt;

  ucode_t     uw;
  logic       advance;
  logic       split;
  logic       repeat_pkt;
  logic [3:0] code;
  logic [7:0] ev_byte;
  logic [7:0] sel_byte;

  assign in_tready  = !busy_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = obyte_r;
  assign out_tuser  = oeop_r;
  assign out_tlast  = olast_r;

  assign uw         = ucode_rom(step_r);
  assign advance    = busy_r && (!ovalid_r || out_tready);
  assign code       = rec_r[11:8];
  assign split      = (code == EV_DOWN_UP);
  assign repeat_pkt = uw.fin && split && !second_r;

  always_comb begin
    if (split) begin
      ev_byte = second_r ? EV_UP : EV_DOWN;
    end else if (code <= EV_MAX_PASS) begin
      ev_byte = {4'd0, code};
    end else begin
      ev_byte = 8'd0;
    end
  end

  always_comb begin
    unique case (uw.src)
      SRC_SYNC:  sel_byte = sync_r;
      SRC_ADDR:  sel_byte = addr_r;
      SRC_MSGID: sel_byte = msgid_r;
      SRC_LEN:   sel_byte = PAYLOAD_LEN;
      SRC_RID:   sel_byte = rec_r[7:0];
      SRC_TYPE:  sel_byte = map_type(rec_r[14:12]);
      SRC_EVENT: sel_byte = ev_byte;
      SRC_XL:    sel_byte = rec_r[39:32];
      SRC_XH:    sel_byte = rec_r[47:40];
      SRC_YL:    sel_byte = rec_r[23:16];
      SRC_YH:    sel_byte = rec_r[31:24];
      default:   sel_byte = end_r;
    endcase
  end

  always_comb begin
    busy_nxt   = busy_r;
    second_nxt = second_r;
    step_nxt   = step_r;
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    oeop_nxt   = oeop_r;
    olast_nxt  = olast_r;
    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      busy_nxt   = 1'b1;
      second_nxt = 1'b0;
      step_nxt   = '0;
    end else if (advance) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = sel_byte;
      oeop_nxt   = uw.eop;
      olast_nxt  = uw.fin && !repeat_pkt;
      if (repeat_pkt) begin
        second_nxt = 1'b1;
        step_nxt   = '0;
      end else if (uw.fin) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      second_r <= 1'b0;
      step_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      second_r <= second_nxt;
      step_r   <= step_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obyte_r <= obyte_nxt;
    oeop_r  <= oeop_nxt;
    olast_r <= olast_nxt;
    if (in_tvalid && in_tready) begin
      rec_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r  <= SYNC_RST;
      addr_r  <= ADDR_RST;
      msgid_r <= MSGID_RST;
      end_r   <= END_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SYNC:  sync_r  <= cfg_wdata;
        CFG_ADDR:  addr_r  <= cfg_wdata;
        CFG_MSGID: msgid_r <= cfg_wdata;
        CFG_END:   end_r   <= cfg_wdata;
        default:   ;
      endcase
    end
  end

endmodule

[test/touch_report_packet_framer_test.sv]
`timescale 1ns / 100ps

module touch_report_packet_framer_test;
  import trpf_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int PRESS_AT    = 2500;
  localparam int TAIL_CYCLES = 30;
  localparam int ITEMS_PER_PHASE = 105;
  localparam int EVENT_POS   = 6;
  // One bit per touch type; a set bit means the type is sent unchanged.
  localparam logic [7:0] TYPE_PASS_MASK = 8'b0111_0110;

  typedef struct packed {
    logic [7:0] x_high;
    logic [7:0] x_low;
    logic [7:0] y_high;
    logic [7:0] y_low;
    logic [7:0] status;
    logic [7:0] report_id;
  } touch_record_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       end_of_packet;
    logic       last;
  } packet_byte_t;

  class packet_scoreboard;
    logic [7:0] sync_byte;
    logic [7:0] addr_byte;
    logic [7:0] msg_id_byte;
    logic [7:0] end_byte;
    packet_byte_t expected_bytes[$];
    int errors;

    function new();
      sync_byte   = SYNC_RST;
      addr_byte   = ADDR_RST;
      msg_id_byte = MSGID_RST;
      end_byte    = END_RST;
      errors      = 0;
    endfunction

    function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
      case (idx)
        CFG_SYNC:  sync_byte   = val;
        CFG_ADDR:  addr_byte   = val;
        CFG_MSGID: msg_id_byte = val;
        CFG_END:   end_byte    = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    // Works out the byte stream that one accepted record must produce.
    function void note_record(input touch_record_t r);
      logic [2:0] kind;
      logic [3:0] code;
      logic [7:0] kind_byte;
      logic [7:0] code_byte;
      logic [7:0] body [PktLen];
      int npkt;
      packet_byte_t e;
      kind = r.status[6:4];
      code = r.status[3:0];
      kind_byte = TYPE_PASS_MASK[kind] ? {5'd0, kind} : 8'd0;
      npkt = (code == EV_DOWN_UP) ? 2 : 1;
      if (code == EV_DOWN_UP)
        code_byte = EV_DOWN;
      else if (code <= EV_MAX_PASS)
        code_byte = {4'd0, code};
      else
        code_byte = 8'd0;
      body = '{sync_byte, addr_byte, msg_id_byte, PAYLOAD_LEN, r.report_id, kind_byte,
               code_byte, r.x_low, r.x_high, r.y_low, r.y_high, end_byte, end_byte};
      for (int p = 0; p < npkt; p++) begin
        // The second packet of a down-and-up record reports the release.
        if (p == 1)
          body[EVENT_POS] = EV_UP;
        for (int i = 0; i < PktLen; i++) begin
          e.packet_byte   = body[i];
          e.end_of_packet = (i == PktLen - 1);
          e.last          = (i == PktLen - 1) && (p == npkt - 1);
          expected_bytes.push_back(e);
        end
      end
    endfunction

    task report(input string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_byte(input logic [7:0] data, input logic eop, input logic fin);
      packet_byte_t e;
      if (expected_bytes.size() == 0) begin
        report($sformatf("byte %02h arrived with nothing expected", data));
        return;
      end
      e = expected_bytes.pop_front();
      if (data !== e.packet_byte)
        report($sformatf("packet byte %02h, expected %02h", data, e.packet_byte));
      if (eop !== e.end_of_packet)
        report($sformatf("end of packet %b, expected %b", eop, e.end_of_packet));
      if (fin !== e.last)
        report($sformatf("last %b, expected %b", fin, e.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;

  packet_scoreboard sb = new();
  int quiet_cycles = 0;
  int sender_calm = 0;
  int receiver_calm = 0;
  int bytes_taken = 0;
  bit pressed = 1'b0;

  touch_report_packet_framer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Draws a gap, with now and then a stretch of back-to-back transactions.
  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0)
      calm = $urandom_range(8, 30);
    return $urandom_range(0, 6);
  endfunction

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic touch_record_t random_record();
    touch_record_t r;
    r.report_id = random_byte();
    r.status    = random_byte();
    r.y_low     = random_byte();
    r.y_high    = random_byte();
    r.x_low     = random_byte();
    r.x_high    = random_byte();
    // Down-and-up records exercise the two-packet path; make them common.
    if ($urandom_range(0, 3) == 0)
      r.status[3:0] = EV_DOWN_UP;
    return r;
  endfunction

  task automatic send_record(input touch_record_t r);
    int gap;
    gap = draw_gap(sender_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] s, input logic [7:0] a,
                            input logic [7:0] m, input logic [7:0] e);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SYNC;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= CFG_ADDR;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_index <= CFG_MSGID;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_index <= CFG_END;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++)
      send_record(random_record());
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en)
        sb.write_reg(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready)
        sb.note_record(in_tdata);
      if (out_tvalid && out_tready)
        sb.check_byte(out_tdata, out_tuser, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the framer backs up its input.
  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_gap(receiver_calm);
      if (!pressed && bytes_taken >= PRESS_AT) begin
        stall = HOLD_CYCLES;
        pressed = 1'b1;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      bytes_taken++;
    end
  end

  initial begin
    touch_record_t r;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values; every touch type and event code, data at both extremes.
    for (int k = 0; k < 16; k++) begin
      r.report_id = k[0] ? 8'hFF : 8'h00;
      r.status    = {k[0], k[2:0], k[3:0]};
      r.y_low     = k[0] ? 8'hFF : 8'h00;
      r.y_high    = k[0] ? 8'hFF : 8'h00;
      r.x_low     = k[0] ? 8'h00 : 8'hFF;
      r.x_high    = k[0] ? 8'h00 : 8'hFF;
      send_record(r);
    end
    r = '{x_high: 8'hA5, x_low: 8'h5A, y_high: 8'h3C, y_low: 8'hC3,
          status: {1'b0, 3'd6, EV_DOWN_UP}, report_id: 8'h81};
    send_record(r);
    r.status = {1'b1, 3'd7, EV_DOWN_UP};
    send_record(r);
    r.status = {1'b1, 3'd0, 4'd10};
    send_record(r);
    r.status = {1'b0, 3'd4, EV_MAX_PASS};
    send_record(r);
    drain();

    write_regs(8'h00, 8'h00, 8'h00, 8'h00);
    send_random(ITEMS_PER_PHASE);
    drain();

    write_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_random(ITEMS_PER_PHASE);
    drain();

    write_regs(random_byte(), random_byte(), random_byte(), random_byte());
    send_random(ITEMS_PER_PHASE);
    drain();

    write_regs(random_byte(), random_byte(), random_byte(), random_byte());
    send_random(ITEMS_PER_PHASE);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected bytes never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
